// ===== rtl/ismv_pkg.sv =====
// Package for the iterated sparse matrix-vector engine: depths, widths, request,
// status and config codes, and the fixed-point product and saturating-add helpers. No dependencies.
`default_nettype none
package ismv_pkg;
	localparam int VecDepth = 1024;
	localparam int NnzDepth = 4096;
	localparam int FracBits = 24;
	localparam int VecAw = $clog2(VecDepth);
	localparam int NnzAw = $clog2(NnzDepth);
	localparam int NnzCw = $clog2(NnzDepth + 1);

	localparam logic [2:0] REQ_LOAD = 3'd0;
	localparam logic [2:0] REQ_APPEND = 3'd1;
	localparam logic [2:0] REQ_RUN = 3'd2;
	localparam logic [2:0] REQ_READ = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	localparam logic [0:0] CFG_LEN = 1'b0;
	localparam logic [0:0] CFG_ITER = 1'b1;

	// Arithmetic shift of a product is floor division by 2^FracBits.
	function automatic logic signed [39:0] scale_product(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p >>> FracBits;
		return s[39:0];
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [39:0] b);
		logic signed [40:0] s;
		s = 41'(a) + 41'(b);
		if (s > 41'sd2147483647) return 32'sh7fffffff;
		else if (s < -41'sd2147483648) return 32'sh80000000;
		else return s[31:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/iterated_sparse_matrix_vector_multiply_top.sv =====
// Iterated sparse matrix-vector engine: one request at a time, each answered by
// a one-cycle done strobe. Loads, appends, clears and unknown requests pass an
// execute state and the strobe before the next acceptance; reads add a state that
// takes the x read. A run, per pass, zeroes y over the active length, walks the
// nonzero list (one read-modify-write of y per in-range nonzero, multiplier
// registered; stale nonzeros skip the write) and copies y into x.
// The receiver cannot stall the strobe.
// Depends on ismv_pkg.
`default_nettype none
module iterated_sparse_matrix_vector_multiply_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  req_type,
	input  wire logic [9:0]  row_index,
	input  wire logic [9:0]  col_index,
	input  wire logic signed [31:0] data_value,
	output logic             done,
	output logic [1:0]       status,
	output logic signed [31:0] result_value,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);
	import ismv_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_EXEC = 4'd1, S_RD = 4'd2, S_ZERO = 4'd3,
		S_NZ_A = 4'd4, S_NZ_B = 4'd5, S_NZ_C = 4'd6, S_NZ_D = 4'd7,
		S_CP_A = 4'd8, S_CP_B = 4'd9, S_DONE = 4'd10;

	logic [3:0] state_q;
	logic [10:0] len_q;
	logic [15:0] iter_cfg_q, iter_q;
	logic [NnzCw-1:0] nnz_cnt_q;
	logic [NnzAw-1:0] k_q;
	logic [VecAw:0] i_q;
	logic [2:0] req_q;
	logic [9:0] row_q, col_q;
	logic signed [31:0] val_q;
	logic [1:0] status_q;
	logic signed [31:0] res_q;

	logic signed [31:0] x_mem [VecDepth];
	logic signed [31:0] y_mem [VecDepth];
	logic [9:0] nr_mem [NnzDepth];
	logic [9:0] nc_mem [NnzDepth];
	logic signed [31:0] nv_mem [NnzDepth];

	logic [VecAw-1:0] x_ra, x_wa, y_ra, y_wa;
	logic x_we, y_we;
	logic signed [31:0] x_wd, y_wd, x_rd, y_rd;
	logic [NnzAw-1:0] nz_ra;
	logic [9:0] nr_rd, nc_rd;
	logic signed [31:0] nv_rd, nv_s1;
	logic signed [63:0] prod_s2;
	logic [9:0] r_s1;
	logic nz_ok;
	logic [10:0] n_act;

	assign n_act = (len_q > 11'(VecDepth)) ? 11'(VecDepth) : len_q;
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign done = (state_q == S_DONE);
	assign status = status_q;
	assign result_value = res_q;

	always_ff @(posedge clk) begin
		if (x_we) x_mem[x_wa] <= x_wd;
		x_rd <= x_mem[x_ra];
		if (y_we) y_mem[y_wa] <= y_wd;
		y_rd <= y_mem[y_ra];
		if (state_q == S_EXEC && req_q == REQ_APPEND && {1'b0, row_q} < n_act
				&& {1'b0, col_q} < n_act && nnz_cnt_q < NnzCw'(NnzDepth)) begin
			nr_mem[k_q] <= row_q;
			nc_mem[k_q] <= col_q;
			nv_mem[k_q] <= val_q;
		end
		nr_rd <= nr_mem[nz_ra];
		nc_rd <= nc_mem[nz_ra];
		nv_rd <= nv_mem[nz_ra];
	end

	assign nz_ok = ({1'b0, nr_rd} < n_act) && ({1'b0, nc_rd} < n_act);

	always_comb begin
		x_ra = row_q[VecAw-1:0];
		x_we = 1'b0;
		x_wa = row_q[VecAw-1:0];
		x_wd = val_q;
		y_ra = i_q[VecAw-1:0];
		y_we = 1'b0;
		y_wa = i_q[VecAw-1:0];
		y_wd = '0;
		nz_ra = k_q;
		case (state_q)
			S_EXEC: x_we = (req_q == REQ_LOAD) && ({1'b0, row_q} < n_act);
			S_ZERO: y_we = 1'b1;
			S_NZ_B: x_ra = nc_rd[VecAw-1:0];
			S_NZ_C: y_ra = r_s1[VecAw-1:0];
			S_NZ_D: begin
				// stale entries skip the write-back
				y_we = nz_ok;
				y_wa = r_s1[VecAw-1:0];
				y_wd = sat_add(y_rd, scale_product(prod_s2));
			end
			S_CP_B: begin
				x_we = 1'b1;
				x_wa = i_q[VecAw-1:0];
				x_wd = y_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_NZ_B) begin
			nv_s1 <= nv_rd;
			r_s1 <= nr_rd;
		end
		if (state_q == S_NZ_C) prod_s2 <= 64'(nv_s1) * 64'(x_rd);
		if (start && !busy) begin
			req_q <= req_type;
			row_q <= row_index;
			col_q <= col_index;
			val_q <= data_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q <= 11'd1024;
			iter_cfg_q <= 16'd1;
			iter_q <= '0;
			nnz_cnt_q <= '0;
			k_q <= '0;
			i_q <= '0;
			status_q <= ST_OK;
			res_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == CFG_LEN) len_q <= cfg_data[10:0];
						else iter_cfg_q <= cfg_data;
					end
					if (start) begin
						state_q <= S_EXEC;
						k_q <= nnz_cnt_q[NnzAw-1:0];
					end
				end
				S_EXEC: begin
					status_q <= ST_OK;
					res_q <= '0;
					state_q <= S_DONE;
					case (req_q)
						REQ_LOAD: if ({1'b0, row_q} >= n_act) status_q <= ST_RANGE;
						REQ_APPEND: begin
							if ({1'b0, row_q} >= n_act || {1'b0, col_q} >= n_act)
								status_q <= ST_RANGE;
							else if (nnz_cnt_q >= NnzCw'(NnzDepth)) status_q <= ST_FULL;
							else nnz_cnt_q <= nnz_cnt_q + 1'b1;
						end
						REQ_READ: begin
							if ({1'b0, row_q} >= n_act) status_q <= ST_RANGE;
							else state_q <= S_RD;
						end
						REQ_CLEAR: nnz_cnt_q <= '0;
						REQ_RUN: begin
							iter_q <= iter_cfg_q;
							i_q <= '0;
							if (iter_cfg_q != 16'd0 && n_act != 11'd0) state_q <= S_ZERO;
						end
						default: status_q <= ST_UNKNOWN;
					endcase
				end
				S_RD: begin
					res_q <= x_rd;
					state_q <= S_DONE;
				end
				S_ZERO: begin
					// clear y over the active length, then walk the list, or copy if it is empty
					if (i_q + 1'b1 >= n_act) begin
						k_q <= '0;
						state_q <= (nnz_cnt_q == '0) ? S_CP_A : S_NZ_A;
						i_q <= '0;
					end else i_q <= i_q + 1'b1;
				end
				S_NZ_A: state_q <= S_NZ_B;
				S_NZ_B: state_q <= nz_ok ? S_NZ_C : S_NZ_D;
				S_NZ_C: state_q <= S_NZ_D;
				S_NZ_D: begin
					if (NnzCw'(k_q) + 1'b1 >= nnz_cnt_q) begin
						state_q <= S_CP_A;
						i_q <= '0;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_NZ_A;
					end
				end
				S_CP_A: state_q <= S_CP_B;
				S_CP_B: begin
					if (i_q + 1'b1 >= n_act) begin
						i_q <= '0;
						if (iter_q == 16'd1) state_q <= S_DONE;
						else begin
							iter_q <= iter_q - 1'b1;
							state_q <= S_ZERO;
						end
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_CP_A;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ismv_checker.sv =====
// Port-level checker for the sparse matrix-vector engine, bound to the top level.
// Depends on the top level's port list only.
`default_nettype none
module ismv_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [1:0] status,
	input wire logic [31:0] result_value,
	input wire logic cfg_ready
);
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("strobe outside a request");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block stays busy after strobe");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != 2'd0 |-> result_value == 32'd0) else $error("failed request with data");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy) else $error("config open while busy");
endmodule
bind iterated_sparse_matrix_vector_multiply_top ismv_checker u_ismv_checker (.*);
`default_nettype wire
